/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the block decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BCD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define BCD_ASSERT(label, prop, msg) \
  `BCD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/bcd_pkg.sv */
// Shared types and constants of the S3TC block decoder.
package bcd_pkg;

  localparam int unsigned MaxSide = 16384;
  localparam int SideW = 15;

  // Reciprocal multipliers for the divisions by 3, 5 and 7.
  localparam int unsigned Recip3 = 683;
  localparam int unsigned Shift3 = 11;
  localparam int unsigned Recip5 = 3277;
  localparam int unsigned Recip7 = 2341;
  localparam int unsigned Shift57 = 14;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Fully decoded block, handed from the palette pipeline to the emitter.
  typedef struct packed {
    logic [63:0]      aw;
    logic [31:0]      idx;
    logic [11:0]      col;
    logic [11:0]      row;
    logic [1:0]       fmt;
    logic [1:0]       last_x;
    logic [1:0]       last_y;
    logic             empty;
    logic [3:0][7:0]  r;
    logic [3:0][7:0]  g;
    logic [3:0][7:0]  b;
    logic [3:0][7:0]  a;
    logic [7:0][7:0]  at;
  } blk_t;

  typedef struct packed {
    logic take;
    logic load;
    logic active;
  } emit_stat_t;

endpackage

/* hw/rtl/bcd_palette_pipe.sv */
// Three-stage pipeline: block capture and clipping, palette sums, palette divides.
module bcd_palette_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [63:0]               alpha_word_i,
  input  logic [63:0]               color_word_i,
  input  logic [11:0]               block_col_i,
  input  logic [11:0]               block_row_i,
  input  logic [1:0]                fmt_i,
  input  logic [bcd_pkg::SideW-1:0] lim_w_i,
  input  logic [bcd_pkg::SideW-1:0] lim_h_i,
  output bcd_pkg::blk_t             blk_o,
  output logic                      blk_valid_o,
  input  logic                      take_i
);

  typedef struct packed {
    logic [63:0] aw;
    logic [63:0] cw;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  fmt;
    logic [1:0]  last_x;
    logic [1:0]  last_y;
    logic        empty;
  } s1_t;

  typedef struct packed {
    logic [63:0]      aw;
    logic [31:0]      idx;
    logic [11:0]      col;
    logic [11:0]      row;
    logic [1:0]       fmt;
    logic [1:0]       last_x;
    logic [1:0]       last_y;
    logic             empty;
    logic             four;
    logic             mode7;
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][9:0]  num2;
    logic [2:0][9:0]  num3;
    logic [5:0][10:0] anum;
  } s2_t;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  bcd_pkg::blk_t s3_d, s3_q;

  assign adv3 = !v3_q || take_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign busy = !adv1;

  // Stage 1: capture, count the columns and rows inside the image.
  localparam int SideW_L = bcd_pkg::SideW;
  logic [SideW_L-1:0] bx, by, dx, dy;
  logic out_x, out_y;

  always_comb begin
    bx = {1'b0, block_col_i, 2'b00};
    by = {1'b0, block_row_i, 2'b00};
    dx = lim_w_i - bx;
    dy = lim_h_i - by;
    out_x = (bx >= lim_w_i);
    out_y = (by >= lim_h_i);
    s1_d.aw = alpha_word_i;
    s1_d.cw = color_word_i;
    s1_d.col = block_col_i;
    s1_d.row = block_row_i;
    s1_d.fmt = fmt_i;
    s1_d.last_x = (dx >= SideW_L'(4)) ? 2'd3 : 2'(dx[1:0] - 2'd1);
    s1_d.last_y = (dy >= SideW_L'(4)) ? 2'd3 : 2'(dy[1:0] - 2'd1);
    s1_d.empty = out_x || out_y;
  end

  // Stage 2: widen endpoints, form the interpolation numerators.
  logic [15:0] c0, c1;
  logic [10:0] a0w, a1w;

  always_comb begin
    c0 = s1_q.cw[15:0];
    c1 = s1_q.cw[31:16];
    a0w = {3'b000, s1_q.aw[7:0]};
    a1w = {3'b000, s1_q.aw[15:8]};
    s2_d.aw = s1_q.aw;
    s2_d.idx = s1_q.cw[63:32];
    s2_d.col = s1_q.col;
    s2_d.row = s1_q.row;
    s2_d.fmt = s1_q.fmt;
    s2_d.last_x = s1_q.last_x;
    s2_d.last_y = s1_q.last_y;
    s2_d.empty = s1_q.empty;
    s2_d.four = (s1_q.fmt != bcd_pkg::FMT_DXT1) || (c0 > c1);
    s2_d.mode7 = s1_q.aw[7:0] > s1_q.aw[15:8];
    s2_d.e0[0] = {c0[15:11], c0[15:13]};
    s2_d.e0[1] = {c0[10:5], c0[10:9]};
    s2_d.e0[2] = {c0[4:0], c0[4:2]};
    s2_d.e1[0] = {c1[15:11], c1[15:13]};
    s2_d.e1[1] = {c1[10:5], c1[10:9]};
    s2_d.e1[2] = {c1[4:0], c1[4:2]};
    for (int k = 0; k < 3; k++) begin
      if (s2_d.four) begin
        s2_d.num2[k] = {1'b0, s2_d.e0[k], 1'b0} + {2'b00, s2_d.e1[k]} + 10'd1;
      end else begin
        s2_d.num2[k] = {2'b00, s2_d.e0[k]} + {2'b00, s2_d.e1[k]};
      end
      s2_d.num3[k] = {2'b00, s2_d.e0[k]} + {1'b0, s2_d.e1[k], 1'b0} + 10'd1;
    end
    for (int i = 0; i < 6; i++) begin
      if (s2_d.mode7) begin
        s2_d.anum[i] = 11'(6 - i) * a0w + 11'(i + 1) * a1w + 11'd3;
      end else if (i < 4) begin
        s2_d.anum[i] = 11'(4 - i) * a0w + 11'(i + 1) * a1w + 11'd2;
      end else begin
        s2_d.anum[i] = 11'd0;
      end
    end
  end

  // Stage 3: reciprocal divides, assemble the palettes.
  logic [2:0][19:0] p2, p3;
  logic [5:0][23:0] p7, p5;

  always_comb begin
    s3_d.aw = s2_q.aw;
    s3_d.idx = s2_q.idx;
    s3_d.col = s2_q.col;
    s3_d.row = s2_q.row;
    s3_d.fmt = s2_q.fmt;
    s3_d.last_x = s2_q.last_x;
    s3_d.last_y = s2_q.last_y;
    s3_d.empty = s2_q.empty;
    for (int k = 0; k < 3; k++) begin
      p2[k] = 20'(s2_q.num2[k]) * 20'(bcd_pkg::Recip3);
      p3[k] = 20'(s2_q.num3[k]) * 20'(bcd_pkg::Recip3);
    end
    s3_d.r[0] = s2_q.e0[0];
    s3_d.g[0] = s2_q.e0[1];
    s3_d.b[0] = s2_q.e0[2];
    s3_d.r[1] = s2_q.e1[0];
    s3_d.g[1] = s2_q.e1[1];
    s3_d.b[1] = s2_q.e1[2];
    if (s2_q.four) begin
      s3_d.r[2] = 8'(p2[0] >> bcd_pkg::Shift3);
      s3_d.g[2] = 8'(p2[1] >> bcd_pkg::Shift3);
      s3_d.b[2] = 8'(p2[2] >> bcd_pkg::Shift3);
      s3_d.r[3] = 8'(p3[0] >> bcd_pkg::Shift3);
      s3_d.g[3] = 8'(p3[1] >> bcd_pkg::Shift3);
      s3_d.b[3] = 8'(p3[2] >> bcd_pkg::Shift3);
    end else begin
      s3_d.r[2] = s2_q.num2[0][8:1];
      s3_d.g[2] = s2_q.num2[1][8:1];
      s3_d.b[2] = s2_q.num2[2][8:1];
      s3_d.r[3] = 8'd0;
      s3_d.g[3] = 8'd0;
      s3_d.b[3] = 8'd0;
    end
    s3_d.a[0] = 8'd255;
    s3_d.a[1] = 8'd255;
    s3_d.a[2] = 8'd255;
    s3_d.a[3] = s2_q.four ? 8'd255 : 8'd0;
    s3_d.at[0] = s2_q.aw[7:0];
    s3_d.at[1] = s2_q.aw[15:8];
    for (int i = 0; i < 6; i++) begin
      p7[i] = 24'(s2_q.anum[i]) * 24'(bcd_pkg::Recip7);
      p5[i] = 24'(s2_q.anum[i]) * 24'(bcd_pkg::Recip5);
      if (s2_q.mode7) begin
        s3_d.at[i + 2] = 8'(p7[i] >> bcd_pkg::Shift57);
      end else if (i < 4) begin
        s3_d.at[i + 2] = 8'(p5[i] >> bcd_pkg::Shift57);
      end else if (i == 4) begin
        s3_d.at[i + 2] = 8'd0;
      end else begin
        s3_d.at[i + 2] = 8'd255;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= start;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
  end

  assign blk_o = s3_q;
  assign blk_valid_o = v3_q;

endmodule

/* hw/rtl/bcd_pixel_emit.sv */
// Pixel emitter: walks the clipped 4x4 block, one registered pixel a cycle.
module bcd_pixel_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcd_pkg::blk_t       blk_i,
  input  logic                blk_valid_i,
  output bcd_pkg::emit_stat_t stat_o,
  output logic                result_valid_o,
  output logic [13:0]         pixel_x_o,
  output logic [13:0]         pixel_y_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic                last_of_block_o
);

  bcd_pkg::blk_t blk_q;
  logic active_q, active_d;
  logic [1:0] px_q, px_d, py_q, py_d;
  logic last_now, take, load;

  logic [3:0] pix;
  logic [1:0] ci;
  logic [3:0] nib;
  logic [2:0] ai;
  logic [5:0] abase;
  logic [7:0] alpha_d;

  logic valid_q;
  logic [13:0] x_q, y_q;
  logic [7:0] r_q, g_q, b_q, a_q;
  logic last_q;

  assign last_now = active_q && (px_q == blk_q.last_x) && (py_q == blk_q.last_y);
  assign take = blk_valid_i && (blk_i.empty || !active_q || last_now);
  assign load = take && !blk_i.empty;

  always_comb begin
    active_d = active_q;
    px_d = px_q;
    py_d = py_q;
    if (load) begin
      active_d = 1'b1;
      px_d = 2'd0;
      py_d = 2'd0;
    end else if (last_now) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (px_q == blk_q.last_x) begin
        px_d = 2'd0;
        py_d = py_q + 2'd1;
      end else begin
        px_d = px_q + 2'd1;
      end
    end
  end

  // Current pixel: index fields sit at 2, 4 and 3 bits per pixel.
  always_comb begin
    pix = {py_q, px_q};
    ci = blk_q.idx[{pix, 1'b0} +: 2];
    nib = blk_q.aw[{pix, 2'b00} +: 4];
    abase = 6'd16 + 6'd3 * {2'b00, pix};
    ai = blk_q.aw[abase +: 3];
    if (blk_q.fmt == bcd_pkg::FMT_DXT1) begin
      alpha_d = blk_q.a[ci];
    end else if (blk_q.fmt == bcd_pkg::FMT_DXT3) begin
      alpha_d = {nib, nib};
    end else begin
      alpha_d = blk_q.at[ai];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      px_q <= 2'd0;
      py_q <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      px_q <= px_d;
      py_q <= py_d;
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) blk_q <= blk_i;
    x_q <= {blk_q.col, px_q};
    y_q <= {blk_q.row, py_q};
    r_q <= blk_q.r[ci];
    g_q <= blk_q.g[ci];
    b_q <= blk_q.b[ci];
    a_q <= alpha_d;
    last_q <= last_now;
  end

  assign stat_o.take = take;
  assign stat_o.load = load;
  assign stat_o.active = active_q;

  assign result_valid_o = valid_q;
  assign pixel_x_o = x_q;
  assign pixel_y_o = y_q;
  assign red_o = r_q;
  assign green_o = g_q;
  assign blue_o = b_q;
  assign alpha_o = a_q;
  assign last_of_block_o = last_q;

endmodule

/* hw/rtl/bc_texture_block_decoder_top.sv */
// Top level of the S3TC (DXT1/DXT3/DXT5) block decoder with APB config port.
`include "assert_macros.svh"

// S3TC block decoder. A block word is taken on an edge with start high and
// busy low. Three pipeline stages (capture and clip, palette sums, palette
// divides) feed a pixel emitter, which sends the block's pixels that fall
// inside the image in row order, one pixel per cycle on result_valid_o,
// with last_of_block_o on the final one. The receiver cannot stall: each
// pixel is on the ports for exactly one cycle. The emitter sets the pace:
// it holds each block until its visible pixels are sent, and the next block
// is loaded on the cycle its last pixel goes out, so interior blocks stream
// with no gap while the pipeline has the next one ready. A block that lies
// wholly outside the image is taken as soon as it is offered and emits nothing.
// When the emitter is free, the first pixel of a block reaches the ports
// via the stage registers, then the emitter's state and output registers.
// busy rises once all three stages hold a block that cannot move on.
// Configuration (format, width, height) must only be written while the
// decoder is idle; widths and heights above 16384 are taken as 16384.
module bc_texture_block_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [63:0] alpha_word_i,
  input  logic [63:0] color_word_i,
  input  logic [11:0] block_col_i,
  input  logic [11:0] block_row_i,
  // result side
  output logic        result_valid_o,
  output logic [13:0] pixel_x_o,
  output logic [13:0] pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_of_block_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SideW = bcd_pkg::SideW;

  logic [1:0]       fmt_q;
  logic [SideW-1:0] width_q, height_q;
  logic [SideW-1:0] lim_w, lim_h;
  logic             cfg_wr;

  bcd_pkg::blk_t       blk;
  logic                blk_valid;
  bcd_pkg::emit_stat_t emit_stat;

  // Register file: word index from paddr[3:2]; other indexes are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= bcd_pkg::FMT_DXT1;
      width_q <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bcd_pkg::REG_FORMAT: fmt_q <= pwdata[1:0];
        bcd_pkg::REG_WIDTH:  width_q <= pwdata[SideW-1:0];
        bcd_pkg::REG_HEIGHT: height_q <= pwdata[SideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bcd_pkg::REG_FORMAT: prdata = {30'd0, fmt_q};
      bcd_pkg::REG_WIDTH:  prdata = {{(32 - SideW){1'b0}}, width_q};
      bcd_pkg::REG_HEIGHT: prdata = {{(32 - SideW){1'b0}}, height_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Clamp the image size to the largest supported side.
  assign lim_w = (width_q > SideW'(bcd_pkg::MaxSide)) ? SideW'(bcd_pkg::MaxSide) : width_q;
  assign lim_h = (height_q > SideW'(bcd_pkg::MaxSide)) ? SideW'(bcd_pkg::MaxSide) : height_q;

  bcd_palette_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .alpha_word_i (alpha_word_i),
    .color_word_i (color_word_i),
    .block_col_i  (block_col_i),
    .block_row_i  (block_row_i),
    .fmt_i        (fmt_q),
    .lim_w_i      (lim_w),
    .lim_h_i      (lim_h),
    .blk_o        (blk),
    .blk_valid_o  (blk_valid),
    .take_i       (emit_stat.take)
  );

  bcd_pixel_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .blk_i           (blk),
    .blk_valid_i     (blk_valid),
    .stat_o          (emit_stat),
    .result_valid_o  (result_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_of_block_o (last_of_block_o)
  );

  // Pixels of one block leave back to back, with no gap, until the last.
  property p_block_contiguous;
    result_valid_o && !last_of_block_o |=> result_valid_o;
  endproperty

  // Within a block, the next pixel is to the right, or starts the next row.
  property p_row_order;
    result_valid_o && !last_of_block_o |=>
      (pixel_x_o == $past(pixel_x_o) + 14'd1 && pixel_y_o == $past(pixel_y_o)) ||
      (pixel_x_o[1:0] == 2'd0 && pixel_y_o == $past(pixel_y_o) + 14'd1);
  endproperty

  `BCD_ASSERT(a_block_contiguous, p_block_contiguous, "gap inside a block")

  `BCD_ASSERT(a_row_order, p_row_order, "pixel out of row order")

  // A loaded block always puts out its first pixel after the emitter's state and output registers.
  `BCD_ASSERT(a_load_emits, emit_stat.load |=> ##1 result_valid_o, "loaded block emitted nothing")

  // The emitter only takes a word that the pipeline offers.
  `BCD_ASSERT(a_take_valid, emit_stat.take |-> blk_valid, "take without a valid block")

endmodule

/* bench/tb_bc_texture_block_decoder_top.sv */
// Self-checking bench for the S3TC block decoder: directed and random blocks, APB setup.
`timescale 1ns / 1ps

module tb_bc_texture_block_decoder_top;
  import bcd_pkg::*;

  // Format code 3 has no enum member; the decoder treats it as DXT5.
  localparam logic [1:0] FmtUnused = 2'd3;
  // Register index with nothing behind it; writes there must be dropped.
  localparam int RegUnused = 3;
  // Cycles to let the pipeline empty of blocks that emit nothing (three stages
  // plus the emitter, with margin) before touching the registers.
  localparam int DrainCycles = 24;
  // Cycles with no word moving on any port before the run is declared hung.
  localparam int StallLimit = 2000;
  localparam int RandomPhases = 8;
  localparam int BlocksPerPhase = 51;

  // One command word: a compressed block and its position.
  typedef struct packed {
    logic [63:0] aw;
    logic [63:0] cw;
    logic [11:0] col;
    logic [11:0] row;
  } block_cmd_t;

  // One decoded pixel as it leaves the result ports.
  typedef struct packed {
    logic [13:0] px;
    logic [13:0] py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  block_cmd_t  cur_block = '0;
  logic        result_valid_o;
  logic [13:0] pixel_x_o;
  logic [13:0] pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        last_of_block_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the decoder's registers, as last written.
  logic [1:0]  fmt_cfg = FMT_DXT1;
  logic [14:0] width_cfg = 15'd1;
  logic [14:0] height_cfg = 15'd1;

  block_cmd_t  block_q[$];   // blocks waiting to be offered
  pixel_t      pixel_q[$];   // pixels the decoder still owes, oldest first

  int idle_pct = 28;         // chance in 100 that the sender skips a cycle
  int blocks_taken = 0;
  int pixels_checked = 0;
  int settings_run = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  bc_texture_block_decoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .alpha_word_i    (cur_block.aw),
    .color_word_i    (cur_block.cw),
    .block_col_i     (cur_block.col),
    .block_row_i     (cur_block.row),
    .result_valid_o  (result_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .last_of_block_o (last_of_block_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected pixels of one block under the current register shadow. Pixels
  // are visited in row order; anything at or past the clipped width/height is
  // dropped, and the final one kept carries the last flag.
  function automatic void decode_block(input block_cmd_t b);
    int unsigned r[4], g[4], bl[4], a[4], at[8];
    int unsigned lim_w, lim_h, px, py, ci, alpha;
    logic [15:0] c0, c1;
    logic [7:0]  idx_row;
    int          kept;
    pixel_t      p;
    kept = 0;
    lim_w = (width_cfg > MaxSide) ? MaxSide : width_cfg;
    lim_h = (height_cfg > MaxSide) ? MaxSide : height_cfg;
    c0 = b.cw[15:0];
    c1 = b.cw[31:16];
    // 565 to 888 by replicating the top bits
    r[0] = {c0[15:11], c0[15:13]};
    g[0] = {c0[10:5], c0[10:9]};
    bl[0] = {c0[4:0], c0[4:2]};
    r[1] = {c1[15:11], c1[15:13]};
    g[1] = {c1[10:5], c1[10:9]};
    bl[1] = {c1[4:0], c1[4:2]};
    for (int i = 0; i < 4; i++) a[i] = 255;
    if (fmt_cfg != FMT_DXT1 || c0 > c1) begin
      r[2] = (2 * r[0] + r[1] + 1) / 3;
      g[2] = (2 * g[0] + g[1] + 1) / 3;
      bl[2] = (2 * bl[0] + bl[1] + 1) / 3;
      r[3] = (r[0] + 2 * r[1] + 1) / 3;
      g[3] = (g[0] + 2 * g[1] + 1) / 3;
      bl[3] = (bl[0] + 2 * bl[1] + 1) / 3;
    end else begin
      // three colours plus transparent black
      r[2] = (r[0] + r[1]) / 2;
      g[2] = (g[0] + g[1]) / 2;
      bl[2] = (bl[0] + bl[1]) / 2;
      r[3] = 0;
      g[3] = 0;
      bl[3] = 0;
      a[3] = 0;
    end
    at[0] = b.aw[7:0];
    at[1] = b.aw[15:8];
    if (at[0] > at[1]) begin
      for (int i = 0; i < 6; i++) at[i + 2] = ((6 - i) * at[0] + (i + 1) * at[1] + 3) / 7;
    end else begin
      for (int i = 0; i < 4; i++) at[i + 2] = ((4 - i) * at[0] + (i + 1) * at[1] + 2) / 5;
      at[6] = 0;
      at[7] = 255;
    end
    for (int y = 0; y < 4; y++) begin
      py = {b.row, 2'b00} + y;
      idx_row = b.cw[32 + 8 * y +: 8];
      for (int x = 0; x < 4; x++) begin
        px = {b.col, 2'b00} + x;
        if (py < lim_h && px < lim_w) begin
          ci = idx_row[2 * x +: 2];
          if (fmt_cfg == FMT_DXT1) begin
            alpha = a[ci];
          end else if (fmt_cfg == FMT_DXT3) begin
            alpha = b.aw[16 * y + 4 * x +: 4] * 17;
          end else begin
            alpha = at[b.aw[16 + 3 * (4 * y + x) +: 3]];
          end
          p.px = px[13:0];
          p.py = py[13:0];
          p.red = r[ci][7:0];
          p.green = g[ci][7:0];
          p.blue = bl[ci][7:0];
          p.alpha = alpha[7:0];
          p.last = 1'b0;
          pixel_q.push_back(p);
          kept++;
        end
      end
    end
    if (kept > 0) begin
      p = pixel_q.pop_back();
      p.last = 1'b1;
      pixel_q.push_back(p);
    end
  endfunction

  // Sender: a block word moves on an edge with start high and busy low. The
  // next one, if any, is put up on that same edge unless the sender idles.
  always @(posedge clk_i or negedge rst_ni) begin : drive_blocks
    block_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        decode_block(cur_block);
        blocks_taken++;
      end
      if (!start || !busy) begin
        if (block_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = block_q.pop_front();
          cur_block <= nxt;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver: every strobed pixel is compared with the oldest one owed.
  always @(posedge clk_i) begin : check_pixels
    pixel_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{pixel_x_o, pixel_y_o, red_o, green_o, blue_o, alpha_o, last_of_block_o};
      if (pixel_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected pixel x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                   got.px, got.py, got.red, got.green, got.blue, got.alpha, got.last);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("pixel mismatch: want x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                     want.px, want.py, want.red, want.green, want.blue, want.alpha,
                     want.last);
            $display("                 got  x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                     got.px, got.py, got.red, got.green, got.blue, got.alpha, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any word on any port (block, pixel, APB) counts as progress.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || psel)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: %0d idle cycles, %0d pixels still owed", stall_cycles,
                 pixel_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [3:0] addr, output logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register and mirror it in the shadow; unknown indexes change nothing.
  task automatic set_reg(input int idx, input logic [31:0] value);
    apb_write(4'(idx * 4), value);
    case (idx)
      REG_FORMAT: fmt_cfg = value[1:0];
      REG_WIDTH:  width_cfg = value[14:0];
      REG_HEIGHT: height_cfg = value[14:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    logic [31:0] got;
    logic [31:0] want[3];
    want[0] = {30'd0, fmt_cfg};
    want[1] = {17'd0, width_cfg};
    want[2] = {17'd0, height_cfg};
    for (int i = 0; i < 3; i++) begin
      apb_read(4'(i * 4), got);
      if (got !== want[i]) begin
        if (mismatches < 10)
          $display("register %0d reads %08h, want %08h", i, got, want[i]);
        mismatches++;
      end
    end
  endtask

  // Wait until no block is queued or on the port and nothing is owed, then let
  // blocks that emit nothing fall out of the pipeline.
  task automatic drain();
    do @(negedge clk_i); while (block_q.size() != 0 || start || pixel_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // New register setting, only ever with the decoder idle. Returns on a
  // falling edge so that queue updates never share a step with the sender.
  task automatic configure(input logic [1:0] f, input int unsigned w, input int unsigned h);
    drain();
    set_reg(REG_FORMAT, f);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    check_regs();
    settings_run++;
    @(negedge clk_i);
  endtask

  task automatic queue_block(input logic [63:0] aw, input logic [63:0] cw,
                             input int unsigned col, input int unsigned row);
    block_q.push_back('{aw, cw, 12'(col), 12'(row)});
  endtask

  // Mostly small images so blocks land near the clipped edges; now and then
  // a full-size or oversized side.
  function automatic int unsigned pick_side();
    case ($urandom_range(14))
      0: pick_side = MaxSide;
      1: pick_side = 32767;
      default: pick_side = $urandom_range(1, 48);
    endcase
  endfunction

  task automatic random_phase(input int n_blocks, input int idle);
    logic [1:0]  f;
    int unsigned w, h, wb, hb;
    block_cmd_t  b;
    f = ($urandom_range(9) == 0) ? FmtUnused : 2'($urandom_range(2));
    w = pick_side();
    h = pick_side();
    configure(f, w, h);
    idle_pct = idle;
    // one block past each edge is allowed, so edge clipping and
    // wholly-outside blocks both turn up
    wb = ((w > MaxSide) ? MaxSide : w) / 4 + 1;
    hb = ((h > MaxSide) ? MaxSide : h) / 4 + 1;
    if (wb > 4095) wb = 4095;
    if (hb > 4095) hb = 4095;
    repeat (n_blocks) begin
      b.aw = {$urandom, $urandom};
      b.cw = {$urandom, $urandom};
      // equal endpoints / equal alpha ends are rare by chance, so force some
      if ($urandom_range(9) == 0) b.cw[31:16] = b.cw[15:0];
      if ($urandom_range(9) == 0) b.aw[15:8] = b.aw[7:0];
      b.col = ($urandom_range(5) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(wb));
      b.row = ($urandom_range(5) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(hb));
      block_q.push_back(b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers straight out of reset, and one block decoded with them
    // (DXT1, 1x1 image: a single pixel).
    check_regs();
    @(negedge clk_i);
    settings_run++;
    queue_block(64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_0000_FFFF, 0, 0);

    // DXT1 on a 14x10 image: both colour modes, equal endpoints, all-zero and
    // all-one words, a corner block clipped both ways, blocks outside.
    configure(FMT_DXT1, 14, 10);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 0, 0);
    queue_block(64'h0, 64'hE4E4_E4E4_FFFF_0000, 1, 0);
    queue_block(64'h0, 64'h1B1B_E4E4_8410_8410, 2, 0);
    queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3, 0);
    queue_block(64'h0, 64'h0, 3, 2);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 4, 0);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 0, 3);
    queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4095, 4095);

    // DXT3: explicit alpha at both ends and a ramp; endpoint0 < endpoint1
    // still gives four colours here.
    configure(FMT_DXT3, 8, 8);
    queue_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hE4E4_E4E4_F800_001F, 0, 0);
    queue_block(64'h0, 64'h1B1B_E4E4_07E0_F81F, 1, 0);
    queue_block(64'h0123_4567_89AB_CDEF, 64'h3636_C9C9_A5A5_5A5A, 0, 1);

    // DXT5: eight-value and six-value alpha tables, equal ends, and the
    // fixed 0/255 entries.
    configure(FMT_DXT5, 4, 4);
    queue_block({48'hFAC688_FAC688, 8'h00, 8'hFF}, 64'hE4E4_E4E4_0000_FFFF, 0, 0);
    queue_block({48'hFAC688_FAC688, 8'hFF, 8'h00}, 64'hE4E4_E4E4_FFFF_0000, 0, 0);
    queue_block({48'hFAC688_FAC688, 8'h80, 8'h80}, 64'hE4E4_E4E4_1234_1234, 0, 0);
    queue_block({48'hDB6DB6_FFFFFF, 8'hF0, 8'h10}, 64'h1B1B_E4E4_4321_8765, 0, 0);

    // Unused format code on a 1x1 image, plus a write to a register that
    // does not exist (the readback must show nothing moved).
    configure(FmtUnused, 1, 1);
    set_reg(RegUnused, 32'hFFFF_FFFF);
    check_regs();
    @(negedge clk_i);
    queue_block({48'hFAC688_FAC688, 8'h00, 8'hFF}, 64'hE4E4_E4E4_0000_FFFF, 0, 0);
    queue_block({48'hFAC688_FAC688, 8'h00, 8'hFF}, 64'hE4E4_E4E4_0000_FFFF, 1, 0);

    // Oversized width, full-size height: the far corners of the largest image.
    configure(FMT_DXT1, 32767, MaxSide);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 4095, 4095);
    queue_block(64'h0, 64'hE4E4_E4E4_FFFF_0000, 4095, 0);
    queue_block(64'h0, 64'h1B1B_E4E4_0000_FFFF, 0, 4095);

    // Empty images emit nothing.
    configure(FMT_DXT1, 0, 8);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 0, 0);
    configure(FMT_DXT3, 8, 0);
    queue_block(64'h0, 64'hE4E4_E4E4_0000_FFFF, 0, 0);

    // Random part: sender idles 28 in 100, then 72 in 100, then never.
    for (int ph = 0; ph < RandomPhases; ph++)
      random_phase(BlocksPerPhase, (ph < 3) ? 28 : (ph < 6) ? 72 : 0);

    drain();
    $display("%0d blocks over %0d register settings, all formats incl. code 3",
             blocks_taken, settings_run);
    $display("%0d pixels checked, %0d mismatches, %0d pixels still owed",
             pixels_checked, mismatches, pixel_q.size());
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
